// ===== src/mmm_pkg.sv =====
// Package: constants, types and register codes for the Montgomery multiplier.
package mmm_pkg;

    localparam int LIMBS_DEF     = 4;
    localparam int LIMB_BITS_DEF = 64;

    // Register stages in one row of the multiplier
    localparam int ROW_DEPTH     = 6;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_MOD0   = 3'd0,
        REG_MOD1   = 3'd1,
        REG_MOD2   = 3'd2,
        REG_MOD3   = 3'd3,
        REG_NEGINV = 3'd4
    } reg_idx_t;

endpackage

// ===== src/mmm_row.sv =====
// One CIOS row: fold in a*b[i], then one reduction word, then shift one word down.
module mmm_row #(
    parameter int LIMBS     = mmm_pkg::LIMBS_DEF,
    parameter int LIMB_BITS = mmm_pkg::LIMB_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [LIMBS*LIMB_BITS-1:0]   in_a,
    input  logic [LIMB_BITS-1:0]         in_bi,
    input  logic [(LIMBS+1)*LIMB_BITS-1:0] in_acc,
    input  logic [LIMBS*LIMB_BITS-1:0]   modulus,
    input  logic [LIMB_BITS-1:0]         neg_inv,
    output logic                         out_valid,
    output logic [(LIMBS+1)*LIMB_BITS-1:0] out_acc
);
    import mmm_pkg::*;

    localparam int W  = LIMBS * LIMB_BITS;
    localparam int WC = (LIMBS + 1) * LIMB_BITS;
    localparam int WA = (LIMBS + 2) * LIMB_BITS;
    // Half-limb width: every multiplier is at most HB by HB bits
    localparam int HB = (LIMB_BITS + 1) / 2;
    localparam int NH = (W + HB - 1) / HB;
    localparam int HW = 2 * HB;

    logic [ROW_DEPTH-1:0] vld_reg;

    // Stage 1: a*b[i] partial products
    logic [NH*HB-1:0]     a_ext;
    logic [HW-1:0]        b_ext;
    logic [HW-1:0]        pab_next [2][NH];
    logic [HW-1:0]        pab_reg  [2][NH];
    logic [WC-1:0]        acc1_reg;
    // Stage 2: t = acc + a*b[i]
    logic [WA-1:0]        pab_sum  [4];
    logic [WA-1:0]        t2_next;
    logic [WA-1:0]        t2_reg;
    // Stage 3: partial products of q
    logic [HW-1:0]        t0_ext;
    logic [HW-1:0]        n_ext;
    logic [HW-1:0]        pq_next  [3];
    logic [HW-1:0]        pq_reg   [3];
    logic [WA-1:0]        t3_reg;
    // Stage 4: q = low word of t*neg_inv
    logic [LIMB_BITS-1:0] q_next;
    logic [LIMB_BITS-1:0] q_reg;
    logic [WA-1:0]        t4_reg;
    // Stage 5: q*m partial products
    logic [NH*HB-1:0]     m_ext;
    logic [HW-1:0]        q_ext;
    logic [HW-1:0]        pqm_next [2][NH];
    logic [HW-1:0]        pqm_reg  [2][NH];
    logic [WA-1:0]        t5_reg;
    // Stage 6: add q*m and drop the low word
    logic [WA-1:0]        pqm_sum  [4];
    logic [WA-1:0]        u_full;
    logic [WC-1:0]        acc_reg;

    // Split a and b[i] into half limbs and multiply
    always_comb begin
        a_ext = (NH*HB)'(in_a);
        b_ext = HW'(in_bi);
        for (int l = 0; l < 2; l++) begin
            for (int k = 0; k < NH; k++) begin
                pab_next[l][k] = HW'(a_ext[k*HB +: HB]) * HW'(b_ext[l*HB +: HB]);
            end
        end
    end

    // Lay out non-overlapping partials side by side, then sum with acc
    always_comb begin
        for (int s = 0; s < 4; s++) begin
            pab_sum[s] = '0;
        end
        for (int l = 0; l < 2; l++) begin
            for (int k = 0; k < NH; k++) begin
                pab_sum[2*l + (k & 1)][(k + l)*HB +: HW] = pab_reg[l][k];
            end
        end
        t2_next = WA'(acc1_reg) + pab_sum[0] + pab_sum[1] + pab_sum[2] + pab_sum[3];
    end

    // Low-word products for q; the high-by-high term falls out of the word
    always_comb begin
        t0_ext     = HW'(t2_reg[LIMB_BITS-1:0]);
        n_ext      = HW'(neg_inv);
        pq_next[0] = HW'(t0_ext[HB-1:0]) * HW'(n_ext[HB-1:0]);
        pq_next[1] = HW'(t0_ext[HB-1:0]) * HW'(n_ext[HW-1:HB]);
        pq_next[2] = HW'(t0_ext[HW-1:HB]) * HW'(n_ext[HB-1:0]);
    end

    assign q_next = LIMB_BITS'(pq_reg[0] + ((pq_reg[1] + pq_reg[2]) << HB));

    // Split m and q into half limbs and multiply
    always_comb begin
        m_ext = (NH*HB)'(modulus);
        q_ext = HW'(q_reg);
        for (int l = 0; l < 2; l++) begin
            for (int k = 0; k < NH; k++) begin
                pqm_next[l][k] = HW'(m_ext[k*HB +: HB]) * HW'(q_ext[l*HB +: HB]);
            end
        end
    end

    // Add q*m to t; the word shift keeps bits LIMB_BITS and up
    always_comb begin
        for (int s = 0; s < 4; s++) begin
            pqm_sum[s] = '0;
        end
        for (int l = 0; l < 2; l++) begin
            for (int k = 0; k < NH; k++) begin
                pqm_sum[2*l + (k & 1)][(k + l)*HB +: HW] = pqm_reg[l][k];
            end
        end
        u_full = t5_reg + pqm_sum[0] + pqm_sum[1] + pqm_sum[2] + pqm_sum[3];
    end

    // Advance valid bits with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[ROW_DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pab_reg  <= pab_next;
            acc1_reg <= in_acc;
            t2_reg   <= t2_next;
            pq_reg   <= pq_next;
            t3_reg   <= t2_reg;
            q_reg    <= q_next;
            t4_reg   <= t3_reg;
            pqm_reg  <= pqm_next;
            t5_reg   <= t4_reg;
            acc_reg  <= u_full[LIMB_BITS +: WC];
        end
    end

    assign out_valid = vld_reg[ROW_DEPTH-1];
    assign out_acc   = acc_reg;
endmodule

// ===== src/montgomery_modular_multiplier_unit.sv =====
// Top level: pipelined 256-bit Montgomery multiplier with APB register port.
//
//  channel | dir | fields
//  s_axis  | in  | tdata: a_word0..3, b_word0..3
//  m_axis  | out | tdata: product_word0..3, no_inverse
//  apb     | in  | modulus_word0..3, neg_inverse_low
//
// One item enters per cycle while m_tready does not stall the pipeline. Each row
// is six register stages (a*b[i] partials, sum, q partials, q, q*m partials,
// add and shift) and one subtract stage follows: 6*LIMBS+1 stages lie between
// an accepted input beat and its offered result.
// Reset clears all valid bits and the configuration registers. A stall on
// m_tready freezes the whole pipeline and holds s_tready low; nothing is lost.
module montgomery_modular_multiplier_unit #(
    parameter int LIMBS     = mmm_pkg::LIMBS_DEF,
    parameter int LIMB_BITS = mmm_pkg::LIMB_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // a words 0..LIMBS-1, then b words 0..LIMBS-1
    input  logic [2*LIMBS*LIMB_BITS-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // product words 0..LIMBS-1, no_inverse, zero fill to whole bytes
    output logic [((LIMBS*LIMB_BITS+1+7)/8)*8-1:0] m_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [$clog2(8*(LIMBS+1))-1:0] paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready
);
    import mmm_pkg::*;

    localparam int W   = LIMBS * LIMB_BITS;
    localparam int WAC = (LIMBS + 1) * LIMB_BITS;
    localparam int OW  = ((W + 1 + 7) / 8) * 8;
    localparam int IW  = $clog2(LIMBS + 1);

    logic [W-1:0]         mod_reg;
    logic [LIMB_BITS-1:0] ninv_reg;
    logic [IW-1:0]        ridx;
    logic                 wr_en;
    logic                 adv;

    // Configuration registers
    assign pready = 1'b1;
    assign ridx   = IW'(paddr >> 3);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg  <= '0;
            ninv_reg <= '0;
        end else if (wr_en) begin
            if (32'(ridx) < LIMBS) begin
                mod_reg[ridx*LIMB_BITS +: LIMB_BITS] <= pwdata[LIMB_BITS-1:0];
            end else if (32'(ridx) == LIMBS) begin
                ninv_reg <= pwdata[LIMB_BITS-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (32'(ridx) < LIMBS) begin
            prdata[LIMB_BITS-1:0] = mod_reg[ridx*LIMB_BITS +: LIMB_BITS];
        end else if (32'(ridx) == LIMBS) begin
            prdata[LIMB_BITS-1:0] = ninv_reg;
        end
    end

    // Pipeline advances when output slot is free or taken
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic [LIMBS:0]       v;
    logic [WAC-1:0]       acc  [LIMBS+1];
    logic [W-1:0]         a_d  [LIMBS];
    logic [W-1:0]         b_d  [LIMBS];

    assign v[0]   = s_tvalid;
    assign acc[0] = '0;
    assign a_d[0] = s_tdata[W-1:0];
    assign b_d[0] = s_tdata[2*W-1:W];

    // One row per operand word; operands travel alongside
    for (genvar i = 0; i < LIMBS; i++) begin : g_row
        mmm_row #(.LIMBS(LIMBS), .LIMB_BITS(LIMB_BITS)) u_row (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .in_valid (v[i]),
            .in_a     (a_d[i]),
            .in_bi    (b_d[i][i*LIMB_BITS +: LIMB_BITS]),
            .in_acc   (acc[i]),
            .modulus  (mod_reg),
            .neg_inv  (ninv_reg),
            .out_valid(v[i+1]),
            .out_acc  (acc[i+1])
        );
        // Delay operands by one row so they meet their accumulator
        if (i < LIMBS - 1) begin : g_dly
            logic [W-1:0] a_dly_reg [ROW_DEPTH];
            logic [W-1:0] b_dly_reg [ROW_DEPTH];
            always_ff @(posedge aclk) begin
                if (adv) begin
                    a_dly_reg[0] <= a_d[i];
                    b_dly_reg[0] <= b_d[i];
                    for (int k = 1; k < ROW_DEPTH; k++) begin
                        a_dly_reg[k] <= a_dly_reg[k-1];
                        b_dly_reg[k] <= b_dly_reg[k-1];
                    end
                end
            end
            assign a_d[i+1] = a_dly_reg[ROW_DEPTH-1];
            assign b_d[i+1] = b_dly_reg[ROW_DEPTH-1];
        end
    end

    // Final conditional subtraction into the output register
    logic [WAC:0]  diff;
    logic [W-1:0]  prod_next;
    logic [W-1:0]  prod_reg;
    logic          noinv_reg;
    logic          mvalid_reg;

    always_comb begin
        diff      = {1'b0, acc[LIMBS]} - {1'b0, WAC'(mod_reg)};
        prod_next = diff[WAC] ? acc[LIMBS][W-1:0] : diff[W-1:0];
        if (!mod_reg[0]) begin
            prod_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (adv) begin
            mvalid_reg <= v[LIMBS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg  <= prod_next;
            noinv_reg <= !mod_reg[0];
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = OW'({noinv_reg, prod_reg});

    // Output holds while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    // Even modulus yields a zero product
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[W] |-> m_tdata[W-1:0] == '0)
        else $error("nonzero product with no_inverse");
    // Input ready follows output side
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready mismatch");
endmodule

// ===== verif/montgomery_modular_multiplier_unit_tb.sv =====
// Testbench for the 256-bit Montgomery multiplier: random and directed operands, scoreboard.
`timescale 1ns / 100ps

module montgomery_modular_multiplier_unit_tb;
    import mmm_pkg::*;

    localparam int NW        = LIMBS_DEF;
    localparam int WB        = LIMB_BITS_DEF;
    localparam int LATENCY   = ROW_DEPTH * NW + 1;
    localparam int CYCLE_CAP = 2000000;
    localparam int PHASE_RND = 240;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    // a_word0..3, b_word0..3
    logic [511:0]   s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    // product_word0..3, no_inverse, zero fill
    logic [263:0]   m_tdata;
    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [5:0]     paddr = '0;
    logic [63:0]    pwdata = '0;
    logic [63:0]    prdata;
    logic           pready;

    montgomery_modular_multiplier_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Register shadow
    logic [WB-1:0]  mod_word [NW];
    logic [WB-1:0]  neg_inv;

    logic [511:0]   operand_q [$];
    logic [256:0]   product_q [$];
    int             error_cnt = 0;
    int             result_cnt = 0;
    int             cycle_cnt = 0;
    int             src_gap = 0;
    int             sink_gap = 0;
    int             hold_cnt = 0;
    bit             hold_done = 1'b0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Abort on a hung run
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("montgomery_modular_multiplier_unit_tb: errors");
            $finish;
        end
    end

    function automatic logic [63:0] mul_add(input logic [63:0] x, input logic [63:0] y,
                                            input logic [63:0] a, input logic [63:0] c,
                                            output logic [63:0] low);
        logic [127:0] s;
        s = {64'b0, x} * {64'b0, y} + {64'b0, a} + {64'b0, c};
        low = s[63:0];
        return s[127:64];
    endfunction

    // Word-serial Montgomery product; bit 256 is the no-inverse flag
    function automatic logic [256:0] montgomery_product(input logic [255:0] a,
                                                        input logic [255:0] b);
        logic [63:0]  acc [NW+2];
        logic [63:0]  carry, q, scrap, lw;
        logic [319:0] u, m;
        if (!mod_word[0][0]) return {1'b1, 256'b0};
        for (int k = 0; k < NW + 2; k++) acc[k] = '0;
        for (int i = 0; i < NW; i++) begin
            carry = '0;
            for (int j = 0; j < NW; j++) begin
                carry = mul_add(a[64*j +: 64], b[64*i +: 64], acc[j], carry, lw);
                acc[j] = lw;
            end
            carry = mul_add(64'd0, 64'd0, acc[NW], carry, lw);
            acc[NW] = lw;
            acc[NW+1] = carry;
            scrap = mul_add(acc[0], neg_inv, 64'd0, 64'd0, q);
            carry = mul_add(q, mod_word[0], acc[0], 64'd0, scrap);
            for (int j = 1; j < NW; j++) begin
                carry = mul_add(q, mod_word[j], acc[j], carry, lw);
                acc[j-1] = lw;
            end
            carry = mul_add(64'd0, 64'd0, acc[NW], carry, lw);
            acc[NW-1] = lw;
            acc[NW] = acc[NW+1] + carry;
        end
        u = {acc[4], acc[3], acc[2], acc[1], acc[0]};
        m = {64'b0, mod_word[3], mod_word[2], mod_word[1], mod_word[0]};
        if (u >= m) u = u - m;
        return {1'b0, u[255:0]};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Driver: offer queued operand pairs with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                product_q.push_back(montgomery_product(s_tdata[255:0], s_tdata[511:256]));
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (operand_q.size() > 0) begin
                    s_tdata <= operand_q.pop_front();
                    s_tvalid <= 1'b1;
                    src_gap <= pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result beat and toggle ready
    always @(posedge aclk) begin
        logic [256:0] want;
        int           bad;
        bad = 0;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                result_cnt <= result_cnt + 1;
                if (product_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_tdata[256:0]);
                    bad++;
                end else begin
                    want = product_q.pop_front();
                    for (int w = 0; w < NW; w++)
                        if (m_tdata[64*w +: 64] !== want[64*w +: 64]) begin
                            $display("%0t: product_word%0d expected %h actual %h", $time, w,
                                     want[64*w +: 64], m_tdata[64*w +: 64]);
                            bad++;
                        end
                    if (m_tdata[256] !== want[256]) begin
                        $display("%0t: no_inverse expected %b actual %b", $time,
                                 want[256], m_tdata[256]);
                        bad++;
                    end
                end
                if (bad > 0) error_cnt <= error_cnt + bad;
            end
            // One long hold-off so the pipeline fills and backs up
            if (!hold_done && result_cnt == 400) begin
                hold_done <= 1'b1;
                hold_cnt <= 300;
                m_tready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                sink_gap <= pick_gap();
            end
        end
    end

    task automatic reg_write(input reg_idx_t idx, input logic [63:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_NEGINV) neg_inv = value;
        else mod_word[idx] = value;
    endtask

    function automatic logic [63:0] inverse_word(input logic [63:0] m0);
        logic [63:0] inv;
        inv = m0;
        repeat (6) inv = inv * (64'd2 - m0 * inv);
        return -inv;
    endfunction

    task automatic load_modulus(input logic [255:0] m, input logic [63:0] ninv);
        reg_write(REG_MOD0, m[63:0]);
        reg_write(REG_MOD1, m[127:64]);
        reg_write(REG_MOD2, m[191:128]);
        reg_write(REG_MOD3, m[255:192]);
        reg_write(REG_NEGINV, ninv);
    endtask

    function automatic logic [255:0] rand_wide();
        logic [255:0] v;
        for (int k = 0; k < 8; k++) v[32*k +: 32] = $urandom;
        return v;
    endfunction

    function automatic logic [255:0] modulus_now();
        return {mod_word[3], mod_word[2], mod_word[1], mod_word[0]};
    endfunction

    // Mostly reduced operands; some left unreduced
    function automatic logic [255:0] pick_operand();
        logic [255:0] m, v;
        m = modulus_now();
        v = rand_wide();
        if (m != 0 && $urandom_range(99) < 80) v = v % m;
        return v;
    endfunction

    task automatic fill_phase();
        logic [255:0] m, top;
        m = modulus_now();
        top = (m == 0) ? '1 : m - 1;
        operand_q.push_back({256'd0, 256'd0});
        operand_q.push_back({256'd1, 256'd1});
        operand_q.push_back({top, top});
        operand_q.push_back({256'd1, top});
        operand_q.push_back({{256{1'b1}}, {256{1'b1}}});
        operand_q.push_back({{64{4'h5}}, {64{4'ha}}});
        operand_q.push_back({{64{4'ha}}, {64{4'h5}}});
        operand_q.push_back({m, 256'd1});
        for (int k = 0; k < PHASE_RND; k++)
            operand_q.push_back({pick_operand(), pick_operand()});
    endtask

    task automatic drain();
        while (operand_q.size() > 0 || s_tvalid || product_q.size() > 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    initial begin
        logic [255:0] m;
        for (int k = 0; k < NW; k++) mod_word[k] = '0;
        neg_inv = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset state: zero modulus, flag only
        fill_phase();
        drain();
        // Random full-size odd modulus, matching inverse word
        m = rand_wide() | 256'd1;
        m[255] = 1'b1;
        load_modulus(m, inverse_word(m[63:0]));
        fill_phase();
        drain();
        // Largest modulus
        m = '1;
        load_modulus(m, inverse_word(m[63:0]));
        fill_phase();
        drain();
        // Smallest odd modulus
        load_modulus(256'd1, inverse_word(64'd1));
        fill_phase();
        drain();
        // Inverse word that does not match
        m = rand_wide() | 256'd1;
        load_modulus(m, {$urandom, $urandom});
        fill_phase();
        drain();
        // Even modulus after odd ones
        m = rand_wide() & ~256'd1;
        load_modulus(m, inverse_word(m[63:0] | 64'd1));
        fill_phase();
        drain();
        // Short odd modulus with zero upper words
        m = (rand_wide() >> 128) | 256'd1;
        load_modulus(m, inverse_word(m[63:0]));
        fill_phase();
        drain();

        if (error_cnt == 0) begin
            $display("montgomery_modular_multiplier_unit_tb: clean");
        end else begin
            $display("montgomery_modular_multiplier_unit_tb: errors");
        end
        $finish;
    end

endmodule
